FILE: design/mpdt_pkg.sv
// shared types and constants for the match point dedup table
// no dependencies; used by match_point_dedup_table
package mpdt_pkg;

  localparam int SCORE_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int THR_W      = 25;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 2'd2;

  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [THR_W-1:0]   THR_RESET   = 25'd100;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_X,
    S_SCALE_Y,
    S_SAT_Y,
    S_RD,
    S_DX,
    S_DY,
    S_CMP,
    S_APPEND,
    S_SORT,
    S_SORT_LAST,
    S_FETCH,
    S_EMIT
  } state_t;

endpackage

FILE: design/mpdt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies; holds the match slots of match_point_dedup_table
module mpdt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/match_point_dedup_table.sv
// match point dedup table: distance based suppression of candidate match points
// depends on mpdt_pkg and mpdt_ram
//
// usage: a command beat is taken when start is high and busy is low.
// in_mode 0 offers a candidate point; in_mode 1 reads out the stored matches in
// descending score order (ties: lower slot first) and then clears the table.
// config writes (cfg_we, cfg_index, cfg_data) are taken at once; the user must
// make them only while idle; the block does not enforce this. a candidate
// flagged infinite is skipped and busy stays low; any other is scaled and set
// up, compared with each stored match (slot read, two squares on the one shared
// multiplier, compare) and appended if there is room, else sets the overflow
// flag; a close match stops the compares and is replaced if the candidate
// scores higher. each readout beat follows a slot ram scan and a fetch; an
// empty table gives one invalid result in the cycle after the command.
// each result is on the out_ ports for one cycle, marked by out_valid; the
// receiver cannot stall. busy drops the cycle the last result is shown.
// reset clears the table count and overflow flag and loads the config defaults;
// slot contents are never read before being written, so they need no clearing.
module match_point_dedup_table #(
  parameter int MAX_MATCHES = 16,
  parameter int COORD_BITS  = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_mode,
  input  logic [COORD_BITS-1:0]                  in_cand_x,
  input  logic [COORD_BITS-1:0]                  in_cand_y,
  input  logic signed [mpdt_pkg::SCORE_W-1:0]    in_cand_score,
  input  logic                                   in_score_infinite,
  input  logic                                   cfg_we,
  input  logic [mpdt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mpdt_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   out_valid,
  output logic [COORD_BITS-1:0]                  out_match_x,
  output logic [COORD_BITS-1:0]                  out_match_y,
  output logic signed [mpdt_pkg::SCORE_W-1:0]    out_score,
  output logic [$clog2(MAX_MATCHES+1)-1:0]       out_match_count,
  output logic                                   out_overflowed,
  output logic                                   out_result_valid,
  output logic                                   out_last_result
);

  localparam int CB    = COORD_BITS;
  localparam int SW    = mpdt_pkg::SCORE_W;
  localparam int CNT_W = $clog2(MAX_MATCHES+1);
  localparam int IDX_W = $clog2(MAX_MATCHES);
  localparam int E_W   = 2*CB + SW;
  localparam int MB_W  = mpdt_pkg::SCALE_W;
  localparam int MP_W  = CB + MB_W;
  localparam int SUM_W = MP_W + 1;
  localparam int SF    = mpdt_pkg::SCALE_FRAC;

  mpdt_pkg::state_t state_r, state_nxt;

  logic [mpdt_pkg::THR_W-1:0]   thr_r;
  logic [mpdt_pkg::SCALE_W-1:0] scl_x_r, scl_y_r;

  logic [CB-1:0]        cx_r, cy_r, px_r, py_r, dy_r;
  logic signed [SW-1:0] cs_r, best_score_r;
  logic [MP_W-1:0]      prod_r, acc_r;
  logic [IDX_W-1:0]     idx_r, best_r, cmp_idx_r;
  logic [CNT_W-1:0]     count_r, k_r;
  logic                 ovf_r, have_r, cmp_v_r;
  logic [MAX_MATCHES-1:0] used_r;

  logic [E_W-1:0]       rd_data;
  logic [CB-1:0]        e_x, e_y, dx;
  logic signed [SW-1:0] e_s;
  logic [SUM_W-1:0]     dist_sum;
  logic                 close, higher, last_pass, last_emit, sat_hi;
  logic [CB+3:0]        shifted;
  logic [CB-1:0]        sat_val;

  logic [CB-1:0]        mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [MP_W-1:0]      mul_p;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [E_W-1:0]       ram_wdata;

  mpdt_ram #(.WIDTH(E_W), .DEPTH(MAX_MATCHES)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // datapath
  always_comb begin
    e_x       = rd_data[E_W-1 -: CB];
    e_y       = rd_data[SW +: CB];
    e_s       = $signed(rd_data[SW-1:0]);
    dx        = (e_x > px_r) ? (e_x - px_r) : (px_r - e_x);
    dist_sum  = SUM_W'(acc_r) + SUM_W'(prod_r);
    close     = dist_sum < SUM_W'(thr_r);
    higher    = cs_r > e_s;
    last_pass = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
    last_emit = (k_r + CNT_W'(1)) == count_r;
    shifted   = prod_r[MP_W-1:SF];
    sat_hi    = |shifted[CB+3:CB];
    sat_val   = sat_hi ? {CB{1'b1}} : shifted[CB-1:0];
    mul_p     = MP_W'(mul_a) * MP_W'(mul_b);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpdt_pkg::S_IDLE: begin
        if (start) begin
          if (in_mode == mpdt_pkg::MODE_OFFER) begin
            state_nxt = in_score_infinite ? mpdt_pkg::S_IDLE : mpdt_pkg::S_SCALE_X;
          end else begin
            state_nxt = (count_r == '0) ? mpdt_pkg::S_IDLE : mpdt_pkg::S_SORT;
          end
        end
      end
      mpdt_pkg::S_SCALE_X: state_nxt = mpdt_pkg::S_SCALE_Y;
      mpdt_pkg::S_SCALE_Y: state_nxt = mpdt_pkg::S_SAT_Y;
      mpdt_pkg::S_SAT_Y: begin
        state_nxt = (count_r == '0) ? mpdt_pkg::S_APPEND : mpdt_pkg::S_RD;
      end
      mpdt_pkg::S_RD: state_nxt = mpdt_pkg::S_DX;
      mpdt_pkg::S_DX: state_nxt = mpdt_pkg::S_DY;
      mpdt_pkg::S_DY: state_nxt = mpdt_pkg::S_CMP;
      mpdt_pkg::S_CMP: begin
        if (close) begin
          state_nxt = mpdt_pkg::S_IDLE;
        end else begin
          state_nxt = last_pass ? mpdt_pkg::S_APPEND : mpdt_pkg::S_RD;
        end
      end
      mpdt_pkg::S_APPEND: state_nxt = mpdt_pkg::S_IDLE;
      mpdt_pkg::S_SORT: begin
        state_nxt = last_pass ? mpdt_pkg::S_SORT_LAST : mpdt_pkg::S_SORT;
      end
      mpdt_pkg::S_SORT_LAST: state_nxt = mpdt_pkg::S_FETCH;
      mpdt_pkg::S_FETCH: state_nxt = mpdt_pkg::S_EMIT;
      mpdt_pkg::S_EMIT: begin
        state_nxt = last_emit ? mpdt_pkg::S_IDLE : mpdt_pkg::S_SORT;
      end
      default: state_nxt = mpdt_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = state_r != mpdt_pkg::S_IDLE;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {px_r, py_r, cs_r};
    ram_raddr = (state_r == mpdt_pkg::S_FETCH) ? best_r : idx_r;
    case (state_r)
      mpdt_pkg::S_SCALE_X: begin
        mul_a = cx_r;
        mul_b = scl_x_r;
      end
      mpdt_pkg::S_SCALE_Y: begin
        mul_a = cy_r;
        mul_b = scl_y_r;
      end
      mpdt_pkg::S_DX: begin
        mul_a = dx;
        mul_b = MB_W'(dx);
      end
      mpdt_pkg::S_DY: begin
        mul_a = dy_r;
        mul_b = MB_W'(dy_r);
      end
      mpdt_pkg::S_CMP: begin
        ram_we = close && higher;
      end
      mpdt_pkg::S_APPEND: begin
        ram_we    = count_r < CNT_W'(MAX_MATCHES);
        ram_waddr = count_r[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mpdt_pkg::S_IDLE;
      thr_r     <= mpdt_pkg::THR_RESET;
      scl_x_r   <= mpdt_pkg::SCALE_RESET;
      scl_y_r   <= mpdt_pkg::SCALE_RESET;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      out_valid <= 1'b0;
      used_r    <= '0;
      have_r    <= 1'b0;
      cmp_v_r   <= 1'b0;
      k_r       <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          mpdt_pkg::REG_DIST_THR: thr_r   <= cfg_data[mpdt_pkg::THR_W-1:0];
          mpdt_pkg::REG_SCALE_X:  scl_x_r <= cfg_data[mpdt_pkg::SCALE_W-1:0];
          mpdt_pkg::REG_SCALE_Y:  scl_y_r <= cfg_data[mpdt_pkg::SCALE_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_r)
        mpdt_pkg::S_IDLE: begin
          if (start && in_mode == mpdt_pkg::MODE_READ) begin
            used_r  <= '0;
            k_r     <= '0;
            idx_r   <= '0;
            have_r  <= 1'b0;
            cmp_v_r <= 1'b0;
            if (count_r == '0) begin
              out_valid <= 1'b1;
              ovf_r     <= 1'b0;
            end
          end
        end
        mpdt_pkg::S_SAT_Y: idx_r <= '0;
        mpdt_pkg::S_CMP: begin
          if (!close) begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        mpdt_pkg::S_APPEND: begin
          if (count_r < CNT_W'(MAX_MATCHES)) begin
            count_r <= count_r + CNT_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        mpdt_pkg::S_SORT, mpdt_pkg::S_SORT_LAST: begin
          cmp_v_r <= state_r == mpdt_pkg::S_SORT;
          if (state_r == mpdt_pkg::S_SORT) begin
            idx_r <= idx_r + IDX_W'(1);
          end
          if (cmp_v_r && !used_r[cmp_idx_r] && (!have_r || e_s > best_score_r)) begin
            have_r <= 1'b1;
          end
        end
        mpdt_pkg::S_EMIT: begin
          out_valid      <= 1'b1;
          used_r[best_r] <= 1'b1;
          k_r            <= k_r + CNT_W'(1);
          idx_r          <= '0;
          have_r         <= 1'b0;
          cmp_v_r        <= 1'b0;
          if (last_emit) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      mpdt_pkg::S_IDLE: begin
        cx_r <= in_cand_x;
        cy_r <= in_cand_y;
        cs_r <= in_cand_score;
        if (start && in_mode == mpdt_pkg::MODE_READ && count_r == '0) begin
          out_match_x      <= '0;
          out_match_y      <= '0;
          out_score        <= '0;
          out_match_count  <= '0;
          out_overflowed   <= ovf_r;
          out_result_valid <= 1'b0;
          out_last_result  <= 1'b1;
        end
      end
      mpdt_pkg::S_SCALE_Y: px_r <= sat_val;
      mpdt_pkg::S_SAT_Y:   py_r <= sat_val;
      mpdt_pkg::S_DX:      dy_r <= (e_y > py_r) ? (e_y - py_r) : (py_r - e_y);
      mpdt_pkg::S_DY:      acc_r <= prod_r;
      mpdt_pkg::S_SORT, mpdt_pkg::S_SORT_LAST: begin
        if (state_r == mpdt_pkg::S_SORT) begin
          cmp_idx_r <= idx_r;
        end
        if (cmp_v_r && !used_r[cmp_idx_r] && (!have_r || e_s > best_score_r)) begin
          best_r       <= cmp_idx_r;
          best_score_r <= e_s;
        end
      end
      mpdt_pkg::S_EMIT: begin
        out_match_x      <= e_x;
        out_match_y      <= e_y;
        out_score        <= e_s;
        out_match_count  <= count_r;
        out_overflowed   <= ovf_r;
        out_result_valid <= 1'b1;
        out_last_result  <= last_emit;
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_MATCHES))
    else $error("slot count above table depth");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |-> out_last_result && out_match_count == '0)
    else $error("invalid result beat not a lone empty readout");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> count_r == '0 && !ovf_r)
    else $error("table not cleared after last readout beat");

  a_skip_infinite: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == mpdt_pkg::MODE_OFFER && in_score_infinite
      |=> !busy && !out_valid)
    else $error("infinite candidate started work");

endmodule

FILE: sim/match_point_dedup_table_tb.sv
// testbench for match_point_dedup_table: directed and random candidate/readout traffic
// checked beat by beat against an in-bench model of the dedup table
// depends on mpdt_pkg and the match_point_dedup_table design files
`timescale 1ns / 1ps

module match_point_dedup_table_tb;

  localparam int SCORE_W    = mpdt_pkg::SCORE_W;
  localparam int SCALE_W    = mpdt_pkg::SCALE_W;
  localparam int SCALE_FRAC = mpdt_pkg::SCALE_FRAC;
  localparam int THR_W      = mpdt_pkg::THR_W;
  localparam int CFG_DATA_W = mpdt_pkg::CFG_DATA_W;
  localparam int CFG_IDX_W  = mpdt_pkg::CFG_IDX_W;

  localparam int NSLOT = 16;
  localparam int CW = 12;
  localparam int CNT_W = $clog2(NSLOT + 1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CW-1:0] COORD_TOP = {CW{1'b1}};
  localparam int DRAIN_CYCLES = 5 + 4 * NSLOT + 11;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 300;

  typedef struct {
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic signed [SCORE_W-1:0]  score;
    logic [CNT_W-1:0]           count;
    logic                       ovf;
    logic                       rvalid;
    logic                       last;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [CW-1:0] in_cand_x = '0;
  logic [CW-1:0] in_cand_y = '0;
  logic signed [SCORE_W-1:0] in_cand_score = '0;
  logic in_score_infinite = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [CW-1:0] out_match_x;
  logic [CW-1:0] out_match_y;
  logic signed [SCORE_W-1:0] out_score;
  logic [CNT_W-1:0] out_match_count;
  logic out_overflowed;
  logic out_result_valid;
  logic out_last_result;

  // table model and its settings
  logic [CW-1:0] tbl_x [NSLOT];
  logic [CW-1:0] tbl_y [NSLOT];
  logic signed [SCORE_W-1:0] tbl_score [NSLOT];
  int tbl_count;
  bit tbl_dropped;
  logic [THR_W-1:0] thr_reg;
  logic [SCALE_W-1:0] sx_reg;
  logic [SCALE_W-1:0] sy_reg;

  match_t pending_matches[$];
  int mismatches = 0;
  int cycle_count = 0;
  int n_offers = 0, n_skipped = 0, n_reads = 0, n_beats = 0;
  int n_replaced = 0, n_dropped = 0, n_writes = 0;
  bit no_gaps = 1'b0;
  int centers_x [8];
  int centers_y [8];

  match_point_dedup_table #(
    .MAX_MATCHES(NSLOT),
    .COORD_BITS (CW)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_cand_x        (in_cand_x),
    .in_cand_y        (in_cand_y),
    .in_cand_score    (in_cand_score),
    .in_score_infinite(in_score_infinite),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_match_x      (out_match_x),
    .out_match_y      (out_match_y),
    .out_score        (out_score),
    .out_match_count  (out_match_count),
    .out_overflowed   (out_overflowed),
    .out_result_valid (out_result_valid),
    .out_last_result  (out_last_result)
  );

  always #10 clk = ~clk;

  function automatic logic [CW-1:0] scaled_pos(logic [CW-1:0] c, logic [SCALE_W-1:0] s);
    logic [CW+SCALE_W-1:0] p;
    logic [CW+SCALE_W-SCALE_FRAC-1:0] q;
    p = c * s;
    q = p[CW+SCALE_W-1:SCALE_FRAC];
    return (q > COORD_TOP) ? COORD_TOP : q[CW-1:0];
  endfunction

  function automatic void absorb_candidate(logic [CW-1:0] x, logic [CW-1:0] y,
                                           logic signed [SCORE_W-1:0] score);
    logic [CW-1:0] px, py;
    longint dx, dy;
    int hit;
    px = scaled_pos(x, sx_reg);
    py = scaled_pos(y, sy_reg);
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      dx = longint'(px) - longint'(tbl_x[i]);
      dy = longint'(py) - longint'(tbl_y[i]);
      if (hit < 0 && dx * dx + dy * dy < longint'(thr_reg)) hit = i;
    end
    if (hit >= 0) begin
      if (score > tbl_score[hit]) begin
        tbl_x[hit] = px;
        tbl_y[hit] = py;
        tbl_score[hit] = score;
        n_replaced++;
      end
    end else if (tbl_count < NSLOT) begin
      tbl_x[tbl_count] = px;
      tbl_y[tbl_count] = py;
      tbl_score[tbl_count] = score;
      tbl_count++;
    end else begin
      tbl_dropped = 1'b1;
      n_dropped++;
    end
  endfunction

  function automatic void dump_table();
    match_t m;
    bit used [NSLOT];
    int best;
    m.count = tbl_count[CNT_W-1:0];
    m.ovf = tbl_dropped;
    if (tbl_count == 0) begin
      m.x = '0;
      m.y = '0;
      m.score = '0;
      m.rvalid = 1'b0;
      m.last = 1'b1;
      pending_matches.insert(pending_matches.size(), m);
    end
    for (int i = 0; i < NSLOT; i++) used[i] = 1'b0;
    for (int k = 0; k < tbl_count; k++) begin
      best = -1;
      for (int i = 0; i < tbl_count; i++)
        if (!used[i] && (best < 0 || tbl_score[i] > tbl_score[best])) best = i;
      used[best] = 1'b1;
      m.x = tbl_x[best];
      m.y = tbl_y[best];
      m.score = tbl_score[best];
      m.rvalid = 1'b1;
      m.last = (k == tbl_count - 1);
      pending_matches.insert(pending_matches.size(), m);
    end
    tbl_count = 0;
    tbl_dropped = 1'b0;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result beat checker
  always @(posedge clk) begin : result_check
    match_t m;
    if (rst_n && out_valid) begin
      n_beats++;
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual x %0d y %0d score %0d",
                 $time, out_match_x, out_match_y, out_score);
      end else begin
        m = pending_matches.pop_front();
        check_field("match_x", longint'(m.x), longint'(out_match_x));
        check_field("match_y", longint'(m.y), longint'(out_match_y));
        check_field("score", longint'(m.score), longint'(out_score));
        check_field("match_count", longint'(m.count), longint'(out_match_count));
        check_field("overflowed", longint'(m.ovf), longint'(out_overflowed));
        check_field("result_valid", longint'(m.rvalid), longint'(out_result_valid));
        check_field("last_result", longint'(m.last), longint'(out_last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit hit, %0d beats still expected", $time,
               pending_matches.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_command(input logic mode, input logic [CW-1:0] x,
                              input logic [CW-1:0] y,
                              input logic signed [SCORE_W-1:0] score, input logic inf);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_cand_x <= x;
    in_cand_y <= y;
    in_cand_score <= score;
    in_score_infinite <= inf;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (mode == mpdt_pkg::MODE_READ) begin
      n_reads++;
      dump_table();
    end else if (inf) begin
      n_skipped++;
    end else begin
      n_offers++;
      absorb_candidate(x, y, score);
    end
  endtask

  task automatic offer(input int x, input int y, input int score);
    send_command(mpdt_pkg::MODE_OFFER, x[CW-1:0], y[CW-1:0], score[SCORE_W-1:0], 1'b0);
  endtask

  task automatic read_out();
    send_command(mpdt_pkg::MODE_READ, CW'($urandom_range(0, 4095)),
                 CW'($urandom_range(0, 4095)), SCORE_W'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
    case (idx)
      mpdt_pkg::REG_DIST_THR: thr_reg = val[THR_W-1:0];
      mpdt_pkg::REG_SCALE_X:  sx_reg = val[SCALE_W-1:0];
      mpdt_pkg::REG_SCALE_Y:  sy_reg = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int thr, input int sx, input int sy);
    logic [CFG_DATA_W-1:0] hi;
    hi = CFG_DATA_W'($urandom());
    write_reg(mpdt_pkg::REG_DIST_THR, thr[CFG_DATA_W-1:0]);
    // junk above the scale width must be ignored
    write_reg(mpdt_pkg::REG_SCALE_X, {hi[CFG_DATA_W-1:SCALE_W], sx[SCALE_W-1:0]});
    write_reg(mpdt_pkg::REG_SCALE_Y, {hi[SCALE_W+:CFG_DATA_W-SCALE_W], sy[SCALE_W-1:0]});
  endtask

  task automatic new_centers();
    for (int i = 0; i < 8; i++) begin
      centers_x[i] = int'($urandom_range(0, 4095));
      centers_y[i] = int'($urandom_range(0, 4095));
    end
  endtask

  function automatic int near(int c);
    int v;
    v = c + int'($urandom_range(0, 24)) - 12;
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // returns 1 when the candidate counts toward the traffic total
  task automatic offer_random(output bit counted);
    int r, k, sc;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    sc = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) == 0) sc = $urandom_range(0, 1) ? 32767 : -32768;
    counted = (r >= 8);
    if (r < 8)
      send_command(mpdt_pkg::MODE_OFFER, CW'($urandom_range(0, 4095)),
                   CW'($urandom_range(0, 4095)), sc[SCORE_W-1:0], 1'b1);
    else if (r < 65)
      offer(near(centers_x[k]), near(centers_y[k]), sc);
    else
      offer($urandom_range(0, 4095), $urandom_range(0, 4095), sc);
  endtask

  task automatic random_burst(input int len, input bit with_reads);
    bit counted;
    for (int i = 0; i < len; i++) begin
      if (with_reads && $urandom_range(0, 11) == 0) read_out();
      else offer_random(counted);
    end
    read_out();
  endtask

  task automatic test_basics();
    no_gaps = 1'b0;
    read_out();
    offer(0, 0, -32768);
    offer(4095, 4095, 32767);
    send_command(mpdt_pkg::MODE_OFFER, 12'd100, 12'd100, 16'sd32767, 1'b1);
    offer(3, 4, -32768);
    offer(3, 4, -100);
    offer(4090, 4095, 5);
    offer(200, 200, 5);
    offer(400, 400, 5);
    read_out();
    read_out();
  endtask

  task automatic test_full_table();
    no_gaps = 1'b1;
    for (int i = 0; i < NSLOT; i++) offer(i * 250, 4095 - i * 250, i * 1000 - 8000);
    offer(2100, 100, 1234);
    offer(1252, 2843, 32767);
    offer(1502, 2593, -32768);
    read_out();
    read_out();
    wait_idle();
  endtask

  task automatic test_config_extremes();
    no_gaps = 1'b0;
    new_centers();
    set_config(0, 4096, 4096);
    offer(50, 50, 1);
    offer(50, 50, 2);
    random_burst(20, 1'b0);
    wait_idle();
    set_config(33554431, 65535, 65535);
    random_burst(20, 1'b1);
    wait_idle();
    set_config(1, 0, 65535);
    random_burst(20, 1'b0);
    wait_idle();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    set_config(100, 4096, 4096);
    random_burst(10, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int total, len, thr;
    bit counted, reads;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      new_centers();
      no_gaps = ($urandom_range(0, 3) == 0);
      reads = $urandom_range(0, 1);
      len = $urandom_range(10, 40);
      for (int i = 0; i < len; i++) begin
        if (reads && $urandom_range(0, 11) == 0) read_out();
        else begin
          offer_random(counted);
          if (counted) total++;
        end
      end
      read_out();
      if ($urandom_range(0, 1)) begin
        wait_idle();
        thr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 33554431) : $urandom_range(0, 400);
        if ($urandom_range(0, 3) == 0)
          set_config(thr, $urandom_range(0, 65535), $urandom_range(0, 65535));
        else
          set_config(thr, $urandom_range(1024, 16384), $urandom_range(1024, 16384));
      end
    end
  endtask

  initial begin
    tbl_count = 0;
    tbl_dropped = 1'b0;
    thr_reg = mpdt_pkg::THR_RESET;
    sx_reg = mpdt_pkg::SCALE_RESET;
    sy_reg = mpdt_pkg::SCALE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basics();
    test_full_table();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    $display("offered %0d candidates (%0d skipped as infinite), %0d readouts, %0d beats",
             n_offers, n_skipped, n_reads, n_beats);
    $display("%0d replacements, %0d candidates dropped on a full table, %0d reg writes",
             n_replaced, n_dropped, n_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
